### src/scd_pkg.sv
`timescale 1ns / 1ps

package scd_pkg;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int RAW_W    = 16;
    localparam int TEMP_W   = 19;
    localparam int STATUS_W = 2;
    localparam int PROD_W   = 21;

    // stream packing, padded to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    // crc and frame constants
    localparam logic [BYTE_W-1:0] CRC_POLY  = 8'h8C;
    localparam logic [BYTE_W-1:0] IDLE_BYTE = 8'hFF;
    localparam logic [POS_W-1:0]  POS_LOW   = 4'd0;
    localparam logic [POS_W-1:0]  POS_HIGH  = 4'd1;
    localparam logic [POS_W-1:0]  CRC_BYTES = 4'd8;
    localparam logic [POS_W-1:0]  POS_DONE  = 4'd9;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_GOOD = 2'd0,
        ST_IDLE = 2'd1,
        ST_HELD = 2'd2
    } t_status;

    // frame tracker to decoder
    typedef struct packed {
        logic             done;
        logic             crc_ok;
        logic             idle;
        logic [RAW_W-1:0] raw;
    } t_frame_evt;

    // reflected crc-8, one byte
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### src/scd_frame.sv
`timescale 1ns / 1ps

module scd_frame (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_advance,
    input  logic [scd_pkg::BYTE_W-1:0]   i_byte,
    input  logic                         i_start,
    output scd_pkg::t_frame_evt          o_evt
);

    logic [scd_pkg::BYTE_W-1:0] r_crc, n_crc;
    logic [scd_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [scd_pkg::BYTE_W-1:0] r_low, n_low;
    logic [scd_pkg::BYTE_W-1:0] r_high, n_high;

    logic [scd_pkg::BYTE_W-1:0] w_crc_eff;
    logic [scd_pkg::POS_W-1:0]  w_pos_eff;

    // a frame start restarts counter and crc before the byte is taken
    assign w_crc_eff = i_start ? '0 : r_crc;
    assign w_pos_eff = i_start ? '0 : r_pos;

    // next state for one byte
    always_comb begin
        n_crc  = r_crc;
        n_pos  = r_pos;
        n_low  = r_low;
        n_high = r_high;
        if (i_advance) begin
            n_crc = w_crc_eff;
            n_pos = w_pos_eff;
            if (w_pos_eff < scd_pkg::CRC_BYTES) begin
                if (w_pos_eff == scd_pkg::POS_LOW) begin
                    n_low = i_byte;
                end
                if (w_pos_eff == scd_pkg::POS_HIGH) begin
                    n_high = i_byte;
                end
                n_crc = scd_pkg::crc8_byte(w_crc_eff, i_byte);
                n_pos = w_pos_eff + 4'd1;
            end else if (w_pos_eff == scd_pkg::CRC_BYTES) begin
                n_pos = scd_pkg::POS_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc  <= '0;
            r_pos  <= '0;
            r_low  <= '0;
            r_high <= '0;
        end else begin
            r_crc  <= n_crc;
            r_pos  <= n_pos;
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    // check byte arrives: report the frame
    always_comb begin
        o_evt.done   = i_valid && (w_pos_eff == scd_pkg::CRC_BYTES);
        o_evt.crc_ok = (w_crc_eff == i_byte);
        o_evt.idle   = (r_low == scd_pkg::IDLE_BYTE) && (r_high == scd_pkg::IDLE_BYTE);
        o_evt.raw    = {r_high, r_low};
    end

endmodule

### src/scd_decode.sv
`timescale 1ns / 1ps

module scd_decode (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scd_pkg::BYTE_W-1:0]    i_cfg_wdata,
    input  logic                          i_advance,
    input  scd_pkg::t_frame_evt           i_evt,
    output logic [scd_pkg::TEMP_W-1:0]    o_temp,
    output scd_pkg::t_status              o_status
);

    logic [scd_pkg::BYTE_W-1:0] r_offset;
    logic [scd_pkg::TEMP_W-1:0] r_last_good, n_last_good;

    logic signed [scd_pkg::PROD_W-1:0] w_raw_ext;
    logic signed [scd_pkg::PROD_W-1:0] w_prod;
    logic signed [scd_pkg::PROD_W-1:0] w_biased;
    logic        [scd_pkg::TEMP_W-1:0] w_scaled;
    logic        [scd_pkg::TEMP_W-1:0] w_good;

    // raw * 625 / 100 == raw * 25 / 4, truncated toward zero
    assign w_raw_ext = $signed({{(scd_pkg::PROD_W-scd_pkg::RAW_W){i_evt.raw[scd_pkg::RAW_W-1]}},
                                i_evt.raw});
    assign w_prod    = (w_raw_ext <<< 4) + (w_raw_ext <<< 3) + w_raw_ext;
    assign w_biased  = w_prod + $signed({{(scd_pkg::PROD_W-2){1'b0}},
                                         w_prod[scd_pkg::PROD_W-1], w_prod[scd_pkg::PROD_W-1]});
    assign w_scaled  = w_biased[scd_pkg::PROD_W-1:2];
    assign w_good    = w_scaled + {{(scd_pkg::TEMP_W-scd_pkg::BYTE_W){1'b0}}, r_offset};

    // result select
    always_comb begin
        if (i_evt.crc_ok) begin
            o_temp   = w_good;
            o_status = scd_pkg::ST_GOOD;
        end else if (i_evt.idle) begin
            o_temp   = '0;
            o_status = scd_pkg::ST_IDLE;
        end else begin
            o_temp   = r_last_good;
            o_status = scd_pkg::ST_HELD;
        end
    end

    // hold last good reading
    always_comb begin
        n_last_good = r_last_good;
        if (i_advance && i_evt.done && i_evt.crc_ok) begin
            n_last_good = w_good;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_last_good <= '0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            r_last_good <= n_last_good;
        end
    end

endmodule

### src/scratchpad_crc_temperature_decode.sv
`timescale 1ns / 1ps
// output: the ninth byte of a frame passes the input register, then its result is stored in the result register
// throughput: one byte per cycle, except while the check byte waits for a full result register to
//   drain; the crc step and the x25/4 scaling sit between the input register and the result register
// reset: synchronous, active low; clears crc, byte counter, kept bytes, last good
//   reading and offset, and empties both registers

module scratchpad_crc_temperature_decode (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [scd_pkg::BYTE_W-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scd_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [7:0] data_byte
    input  logic                              s_axis_tuser,  // [0] frame_start
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [scd_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [18:0] temperature, rest zero
    output logic [scd_pkg::STATUS_W-1:0]      m_axis_tuser   // [1:0] status
);

    logic                         r_in_valid;
    logic [scd_pkg::BYTE_W-1:0]   r_in_byte;
    logic                         r_in_start;

    logic                         r_out_valid;
    logic [scd_pkg::TEMP_W-1:0]   r_out_temp;
    logic [scd_pkg::STATUS_W-1:0] r_out_status;

    scd_pkg::t_frame_evt          w_evt;
    logic [scd_pkg::TEMP_W-1:0]   w_temp;
    scd_pkg::t_status             w_status;
    logic                         w_advance;

    // the held byte moves on unless it yields a result that cannot be stored
    assign w_advance     = r_in_valid && (!w_evt.done || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata[scd_pkg::BYTE_W-1:0];
            r_in_start <= s_axis_tuser;
        end
    end

    scd_frame u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_in_valid),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_start   (r_in_start),
        .o_evt     (w_evt)
    );

    scd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_advance),
        .i_evt       (w_evt),
        .o_temp      (w_temp),
        .o_status    (w_status)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_evt.done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_evt.done) begin
            r_out_temp   <= w_temp;
            r_out_status <= w_status;
        end
    end

    // master side transaction
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(scd_pkg::M_TDATA_W-scd_pkg::TEMP_W){1'b0}}, r_out_temp};
    assign m_axis_tuser  = r_out_status;

endmodule
